// ----- rtl/pairwise_gravity_velocity_update_defines.svh -----
// Assertion macros for the pairwise gravity kick pipeline.
// Expects clk and rst in the scope of the module that uses them.
`ifndef PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH
`define PAIRWISE_GRAVITY_VELOCITY_UPDATE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PGVU_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define PGVU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pgvu_pkg.sv -----
// Package for the pairwise gravity kick pipeline: widths, payload types
// and the saturating velocity update. No dependencies.
package pgvu_pkg;

  localparam int VAL_W     = 32;               // Q16.16 position / velocity
  localparam int MASS_W    = 24;
  localparam int G_W       = 32;               // unsigned Q16.16 gravity constant
  localparam logic [G_W-1:0] G_RESET = 32'h0001_0000;

  localparam int DIFF_W    = VAL_W + 1;        // dx, dy and their magnitudes
  localparam int D2_W      = 2 * DIFF_W;       // dx^2 + dy^2
  localparam int GM_P_W    = G_W + MASS_W;     // G * mass
  localparam int GM_W      = GM_P_W + 4;       // G * mass * 10
  localparam int GM_HALF   = GM_W / 2;
  localparam int PP_W      = GM_HALF + DIFF_W; // partial product of gm * |c|
  localparam int MAGP_W    = GM_W + DIFF_W;    // gm * |c|
  localparam int FRAC_SHIFT = 32;
  localparam int NUM_W     = MAGP_W + FRAC_SHIFT;

  localparam int R_W       = DIFF_W + 1;       // integer square root of d2
  localparam int REM_W     = 2 * R_W;
  localparam int DEN_LO    = D2_W / 2;
  localparam int DPP_W     = DEN_LO + R_W;     // partial product of d2 * r
  localparam int DENX_W    = DPP_W + DEN_LO;
  localparam int DEN_W     = 99;               // d2 * r stays below 2^98

  localparam int QB        = 33;               // quotient bits below the cap
  localparam int KICK_W    = QB + 1;
  localparam int CMP_W     = DEN_W + QB;
  localparam logic [KICK_W-1:0] KICK_CAP = KICK_W'(1) << QB;

  localparam int SQRT_LAT  = R_W;
  localparam int DIV_LAT   = QB + 1;
  localparam int SUM_W     = KICK_W + 2;

  typedef struct packed {
    logic signed [VAL_W-1:0] fvx;
    logic signed [VAL_W-1:0] fvy;
    logic signed [VAL_W-1:0] svx;
    logic signed [VAL_W-1:0] svy;
  } vel_t;

  typedef struct packed {
    vel_t vel;
    logic sx;     // dx >= 0
    logic sy;     // dy >= 0
    logic coin;
  } side_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] nfvx;
    logic signed [VAL_W-1:0] nfvy;
    logic signed [VAL_W-1:0] nsvx;
    logic signed [VAL_W-1:0] nsvy;
    logic                    coin;
  } res_t;

  // Add or subtract a kick magnitude and clamp to the signed 32 bit range.
  function automatic logic signed [VAL_W-1:0] kick_apply(
    logic signed [VAL_W-1:0] v, logic add, logic [KICK_W-1:0] k);
    logic signed [SUM_W-1:0] ke;
    logic signed [SUM_W-1:0] s;
    ke = signed'({2'b00, k});
    s  = add ? SUM_W'(v) + ke : SUM_W'(v) - ke;
    if (s[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){s[SUM_W-1]}}) begin
      return s[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end
    return signed'(s[VAL_W-1:0]);
  endfunction

endpackage

// ----- rtl/pgvu_channels.sv -----
// Valid/ready channel interfaces for body pairs in and velocities out.
// Depends on pgvu_pkg.
interface pgvu_in_if;
  import pgvu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  first_pos_x;
  logic signed [VAL_W-1:0]  first_pos_y;
  logic        [MASS_W-1:0] first_mass;
  logic signed [VAL_W-1:0]  first_vel_x;
  logic signed [VAL_W-1:0]  first_vel_y;
  logic signed [VAL_W-1:0]  second_pos_x;
  logic signed [VAL_W-1:0]  second_pos_y;
  logic        [MASS_W-1:0] second_mass;
  logic signed [VAL_W-1:0]  second_vel_x;
  logic signed [VAL_W-1:0]  second_vel_y;

  modport source(output valid, first_pos_x, first_pos_y, first_mass, first_vel_x,
                 first_vel_y, second_pos_x, second_pos_y, second_mass, second_vel_x,
                 second_vel_y, input ready);
  modport sink(input valid, first_pos_x, first_pos_y, first_mass, first_vel_x,
               first_vel_y, second_pos_x, second_pos_y, second_mass, second_vel_x,
               second_vel_y, output ready);
endinterface

interface pgvu_out_if;
  import pgvu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] new_first_vel_x;
  logic signed [VAL_W-1:0] new_first_vel_y;
  logic signed [VAL_W-1:0] new_second_vel_x;
  logic signed [VAL_W-1:0] new_second_vel_y;
  logic                    coincident;

  modport source(output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
                 new_second_vel_y, coincident, input ready);
  modport sink(input valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
               new_second_vel_y, coincident, output ready);
endinterface

// ----- rtl/pairwise_gravity_velocity_update.sv -----
// Top level of the pairwise gravity kick: pair in, four kicked velocities out.
// Depends on pgvu_pkg, pgvu_channels, pgvu_isqrt, pgvu_kdiv and the defines header.
//
//  channel  | kind   | dir | payload
//  ---------+--------+-----+-----------------------------------------------
//  in_ch    | stream | in  | two bodies: position, mass, velocity
//  out_ch   | stream | out | four new velocities, coincident flag
//  cfg_*    | write  | in  | gravity_constant, unsigned Q16.16
//
// One pair enters every cycle while input ready is high.
// The latency is set mostly by the 34-stage square root and the 34-stage dividers.
// Reset clears valid bits and loads G with 1.0; no clearing pass is needed.
// A stall at the output freezes the whole pipe in the next cycle: the last
// stage spills into a one-beat skid register, and input ready drops only
// while that register is full.
`include "pairwise_gravity_velocity_update_defines.svh"

module pairwise_gravity_velocity_update (
  input  logic                     clk,
  input  logic                     rst,
  pgvu_in_if.sink                  in_ch,
  pgvu_out_if.source               out_ch,
  input  logic                     cfg_wen,
  input  logic [pgvu_pkg::G_W-1:0] cfg_wdata
);
  import pgvu_pkg::*;

  localparam int FRONT_LAT = 4;   // difference, magnitude, squares, sums
  localparam int DEN_LAT   = 2;   // d2 * r partial products, then their sum
  localparam int PIPE_LAT  = FRONT_LAT + SQRT_LAT + DEN_LAT + DIV_LAT + 1;
  localparam int NUM_DLY   = SQRT_LAT + DEN_LAT;
  localparam int SIDE_DLY  = SQRT_LAT + DEN_LAT + DIV_LAT;

  logic [G_W-1:0]      grav;
  logic                adv;
  logic                skid_full;
  res_t                skid;
  res_t                res;
  logic [PIPE_LAT-1:0] vld;

  // Gravity constant; the user must write it only while the pipe is empty (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      grav <= G_RESET;
    end else if (cfg_wen) begin
      grav <= cfg_wdata;
    end
  end

  // Advance every stage together unless the skid register holds a beat.
  assign adv         = !skid_full;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_ch.valid};
    end
  end

  // Stage A: coordinate differences and G * mass.
  logic signed [DIFF_W-1:0] a_dx, a_dy;
  logic [GM_P_W-1:0]        a_pf, a_ps;
  vel_t                     a_vel;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_dx  <= DIFF_W'(in_ch.second_pos_x) - DIFF_W'(in_ch.first_pos_x);
      a_dy  <= DIFF_W'(in_ch.second_pos_y) - DIFF_W'(in_ch.first_pos_y);
      a_pf  <= grav * in_ch.second_mass;   // pull on the first body
      a_ps  <= grav * in_ch.first_mass;    // pull on the second body
      a_vel <= '{fvx: in_ch.first_vel_x, fvy: in_ch.first_vel_y,
                 svx: in_ch.second_vel_x, svy: in_ch.second_vel_y};
    end
  end

  // Stage B: magnitudes, signs, coincidence, and the factor of ten.
  logic [DIFF_W-1:0] b_ax, b_ay;
  logic [GM_W-1:0]   b_gmf, b_gms;
  side_t             b_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ax        <= a_dx[DIFF_W-1] ? DIFF_W'(-a_dx) : DIFF_W'(a_dx);
      b_ay        <= a_dy[DIFF_W-1] ? DIFF_W'(-a_dy) : DIFF_W'(a_dy);
      b_gmf       <= (GM_W'(a_pf) << 3) + (GM_W'(a_pf) << 1);
      b_gms       <= (GM_W'(a_ps) << 3) + (GM_W'(a_ps) << 1);
      b_side.vel  <= a_vel;
      b_side.sx   <= !a_dx[DIFF_W-1];
      b_side.sy   <= !a_dy[DIFF_W-1];
      b_side.coin <= (a_dx == '0) && (a_dy == '0);
    end
  end

  // Stage C: squares and split products gm * |c|.
  // Kick slots: first x, first y, second x, second y.
  logic [D2_W-1:0]   c_sqx, c_sqy;
  logic [PP_W-1:0]   c_plo [4];
  logic [PP_W-1:0]   c_phi [4];
  side_t             c_side;
  logic [GM_W-1:0]   gm_sel  [4];
  logic [DIFF_W-1:0] mag_sel [4];

  always_comb begin
    gm_sel[0]  = b_gmf;  mag_sel[0] = b_ax;
    gm_sel[1]  = b_gmf;  mag_sel[1] = b_ay;
    gm_sel[2]  = b_gms;  mag_sel[2] = b_ax;
    gm_sel[3]  = b_gms;  mag_sel[3] = b_ay;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sqx  <= b_ax * b_ax;
      c_sqy  <= b_ay * b_ay;
      c_side <= b_side;
      for (int k = 0; k < 4; k++) begin
        c_plo[k] <= gm_sel[k][GM_HALF-1:0] * mag_sel[k];
        c_phi[k] <= gm_sel[k][GM_W-1:GM_HALF] * mag_sel[k];
      end
    end
  end

  // Stage D: d2 and full numerator magnitudes.
  logic [D2_W-1:0]   d_d2;
  logic [MAGP_W-1:0] d_magp [4];
  side_t             d_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_d2   <= c_sqx + c_sqy;
      d_side <= c_side;
      for (int k = 0; k < 4; k++) begin
        d_magp[k] <= (MAGP_W'(c_phi[k]) << GM_HALF) + MAGP_W'(c_plo[k]);
      end
    end
  end

  // Square root of d2, with d2, numerators and sideband delayed alongside.
  logic [R_W-1:0]    sq_root;
  logic [D2_W-1:0]   d2_dl   [SQRT_LAT];
  logic [MAGP_W-1:0] magp_dl [4][NUM_DLY];
  side_t             side_dl [SIDE_DLY];

  pgvu_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (d_d2),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_dl[0]   <= d_d2;
      side_dl[0] <= d_side;
      for (int i = 1; i < SQRT_LAT; i++) d2_dl[i] <= d2_dl[i-1];
      for (int i = 1; i < SIDE_DLY; i++) side_dl[i] <= side_dl[i-1];
      for (int k = 0; k < 4; k++) begin
        magp_dl[k][0] <= d_magp[k];
        for (int i = 1; i < NUM_DLY; i++) magp_dl[k][i] <= magp_dl[k][i-1];
      end
    end
  end

  // Stages E and F: denominator d2 * r from two partial products.
  logic [DPP_W-1:0] e_plo, e_phi;
  logic [DEN_W-1:0] f_den;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_plo <= d2_dl[SQRT_LAT-1][DEN_LO-1:0] * sq_root;
      e_phi <= d2_dl[SQRT_LAT-1][D2_W-1:DEN_LO] * sq_root;
      f_den <= DEN_W'((DENX_W'(e_phi) << DEN_LO) + DENX_W'(e_plo));
    end
  end

  // Four kick dividers share the denominator.
  logic [KICK_W-1:0] kick [4];

  for (genvar k = 0; k < 4; k++) begin : g_kick
    pgvu_kdiv u_kdiv (
      .clk  (clk),
      .en   (adv),
      .num  ({magp_dl[k][NUM_DLY-1], {FRAC_SHIFT{1'b0}}}),
      .den  (f_den),
      .kick (kick[k])
    );
  end

  // Stage G: apply kicks with saturation; coincident pairs pass through.
  side_t gs;
  assign gs = side_dl[SIDE_DLY-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      res.nfvx <= gs.coin ? gs.vel.fvx : kick_apply(gs.vel.fvx, gs.sx, kick[0]);
      res.nfvy <= gs.coin ? gs.vel.fvy : kick_apply(gs.vel.fvy, gs.sy, kick[1]);
      res.nsvx <= gs.coin ? gs.vel.svx : kick_apply(gs.vel.svx, !gs.sx, kick[2]);
      res.nsvy <= gs.coin ? gs.vel.svy : kick_apply(gs.vel.svy, !gs.sy, kick[3]);
      res.coin <= gs.coin;
    end
  end

  // Skid register: catch the last stage when the sink stalls, drain on ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_ch.ready) skid_full <= 1'b0;
    end else if (vld[PIPE_LAT-1] && !out_ch.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid <= res;
    end
  end

  res_t shown;
  assign shown                   = skid_full ? skid : res;
  assign out_ch.valid            = skid_full || vld[PIPE_LAT-1];
  assign out_ch.new_first_vel_x  = shown.nfvx;
  assign out_ch.new_first_vel_y  = shown.nfvy;
  assign out_ch.new_second_vel_x = shown.nsvx;
  assign out_ch.new_second_vel_y = shown.nsvy;
  assign out_ch.coincident       = shown.coin;

  `PGVU_ASSERT_NEXT(a_stall_freezes, !adv, $stable(vld), "valid bits moved during a stall")
  `PGVU_ASSERT_NEXT(a_skid_holds, skid_full && !out_ch.ready, skid_full && $stable(skid), "skid beat lost")
  `PGVU_ASSERT_HOLDS(a_skid_cause, $rose(skid_full), $past(vld[PIPE_LAT-1] && !out_ch.ready), "skid filled without a stalled beat")

endmodule

// ----- rtl/pgvu_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on pgvu_pkg.
module pgvu_isqrt (
  input  logic                     clk,
  input  logic                     en,
  input  logic [pgvu_pkg::D2_W-1:0] radicand,
  output logic [pgvu_pkg::R_W-1:0]  root
);
  import pgvu_pkg::*;

  logic [REM_W-1:0] rem  [R_W-1];
  logic [R_W-1:0]   rt   [R_W];

  for (genvar s = 0; s < R_W; s++) begin : g_stage
    localparam int B = R_W - 1 - s;
    logic [REM_W-1:0] rem_in;
    logic [R_W-1:0]   rt_in;
    logic [REM_W-1:0] trial;
    logic             take;

    if (s == 0) begin : g_first
      assign rem_in = REM_W'(radicand);
      assign rt_in  = '0;
    end else begin : g_rest
      assign rem_in = rem[s-1];
      assign rt_in  = rt[s-1];
    end

    // (r + 2^B)^2 - r^2, with r holding bits above B only
    always_comb begin
      trial = (REM_W'(rt_in) << (B + 1)) | (REM_W'(1) << (2 * B));
      take  = rem_in >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[s] <= take ? (rt_in | (R_W'(1) << B)) : rt_in;
      end
    end

    if (s < R_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= take ? rem_in - trial : rem_in;
        end
      end
    end
  end

  assign root = rt[R_W-1];

endmodule

// ----- rtl/pgvu_kdiv.sv -----
// Pipelined restoring divider for one kick magnitude, capped at 2^33.
// Depends on pgvu_pkg.
module pgvu_kdiv (
  input  logic                        clk,
  input  logic                        en,
  input  logic [pgvu_pkg::NUM_W-1:0]  num,
  input  logic [pgvu_pkg::DEN_W-1:0]  den,
  output logic [pgvu_pkg::KICK_W-1:0] kick
);
  import pgvu_pkg::*;

  logic [NUM_W-1:0]   rem [QB];
  logic [DEN_W-1:0]   dsr [QB];
  logic [QB-1:0]      quo [DIV_LAT];
  logic [DIV_LAT-1:0] cap;

  // First stage: a quotient of 2^33 or more saturates to the cap.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dsr[0] <= den;
      quo[0] <= '0;
      cap[0] <= CMP_W'(num) >= (CMP_W'(den) << QB);
    end
  end

  for (genvar s = 1; s < DIV_LAT; s++) begin : g_stage
    localparam int J = QB - s;
    logic [CMP_W-1:0] trial;
    logic             take;

    always_comb begin
      trial = CMP_W'(dsr[s-1]) << J;
      take  = CMP_W'(rem[s-1]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[s] <= take ? (quo[s-1] | (QB'(1) << J)) : quo[s-1];
        cap[s] <= cap[s-1];
      end
    end

    if (s < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s] <= take ? NUM_W'(CMP_W'(rem[s-1]) - trial) : rem[s-1];
          dsr[s] <= dsr[s-1];
        end
      end
    end
  end

  assign kick = cap[DIV_LAT-1] ? KICK_CAP : KICK_W'(quo[DIV_LAT-1]);

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for pairwise_gravity_velocity_update.
// Depends on pgvu_pkg, the pgvu_in_if / pgvu_out_if channels and the RTL top.
`timescale 1ns / 100ps

module testbench;
  import pgvu_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int PIPE_LAT     = 75;     // beat latency stated by the block
  localparam int STALL_LIMIT  = 3000;   // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int PHASE_ITEMS  = 400;
  localparam int NUM_PHASES   = 5;

  typedef struct packed {
    logic signed [VAL_W-1:0]  first_pos_x;
    logic signed [VAL_W-1:0]  first_pos_y;
    logic        [MASS_W-1:0] first_mass;
    logic signed [VAL_W-1:0]  first_vel_x;
    logic signed [VAL_W-1:0]  first_vel_y;
    logic signed [VAL_W-1:0]  second_pos_x;
    logic signed [VAL_W-1:0]  second_pos_y;
    logic        [MASS_W-1:0] second_mass;
    logic signed [VAL_W-1:0]  second_vel_x;
    logic signed [VAL_W-1:0]  second_vel_y;
  } body_pair_t;

  typedef struct packed {
    body_pair_t pair;
    logic       typed;   // expected velocities given in the row
    res_t       vels;
  } kick_row_t;

  localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VMIN = 32'h8000_0000;
  localparam logic [23:0] MMAX = 24'hFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [G_W-1:0] cfg_wdata = '0;

  pgvu_in_if  in_ch();
  pgvu_out_if out_ch();

  pairwise_gravity_velocity_update dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model copy of the gravity constant; tracks every register write.
  logic [G_W-1:0] grav_g = G_RESET;
  res_t           kicked_q[$];   // expected velocities, oldest first
  int             errors = 0;
  int             pairs_in = 0, vels_out = 0, coin_seen = 0;
  int             tx_idle_pct = 25, rx_idle_pct = 75;
  bit             hold_req = 1'b0;

  // ---------------------------------------------------------------- predictor
  // Integer square root of the squared distance, raw LSBs.
  function automatic logic [33:0] dist_root(logic [127:0] d2);
    logic [33:0]  root;
    logic [127:0] t;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      t = 128'(root | (34'd1 << b));
      if (t * t <= d2) root = 34'(t);
    end
    return root;
  endfunction

  // floor(G * mass * 10 * |c| * 2^32 / den), capped at 2^33.
  function automatic logic [KICK_W-1:0] kick_mag(logic [23:0] mass, logic [32:0] mag,
                                                 logic [127:0] den);
    logic [127:0] num, q;
    num = ((128'(grav_g) * 128'(mass) * 128'd10) * 128'(mag)) << 32;
    q   = num / den;
    return (q > 128'(KICK_CAP)) ? KICK_CAP : KICK_W'(q);
  endfunction

  // Add or subtract a kick and clamp to the signed 32 bit range.
  function automatic logic signed [31:0] kick_vel(logic signed [31:0] v, logic up,
                                                  logic [KICK_W-1:0] k);
    logic signed [63:0] s;
    s = up ? 64'(v) + $signed(64'(k)) : 64'(v) - $signed(64'(k));
    if (s > 64'sh7FFF_FFFF) return VMAX;
    if (s < -64'sh8000_0000) return VMIN;
    return s[31:0];
  endfunction

  function automatic res_t predict_kick(body_pair_t p);
    logic signed [33:0] dx, dy;
    logic [32:0]        ax, ay;
    logic [127:0]       d2, den;
    res_t               r;
    dx = p.second_pos_x - p.first_pos_x;
    dy = p.second_pos_y - p.first_pos_y;
    ax = 33'(dx < 0 ? -dx : dx);
    ay = 33'(dy < 0 ? -dy : dy);
    if (ax == 0 && ay == 0) begin
      r = '{p.first_vel_x, p.first_vel_y, p.second_vel_x, p.second_vel_y, 1'b1};
      return r;
    end
    d2  = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
    den = d2 * 128'(dist_root(d2));
    r.nfvx = kick_vel(p.first_vel_x,  dx >= 0, kick_mag(p.second_mass, ax, den));
    r.nfvy = kick_vel(p.first_vel_y,  dy >= 0, kick_mag(p.second_mass, ay, den));
    r.nsvx = kick_vel(p.second_vel_x, dx < 0,  kick_mag(p.first_mass,  ax, den));
    r.nsvy = kick_vel(p.second_vel_y, dy < 0,  kick_mag(p.first_mass,  ay, den));
    r.coin = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------- directed table
  // Typed rows: coincident pass-through, capped kicks, and two massless bodies.
  // The rest go through the predictor. All rows run with G at its reset value.
  kick_row_t dir_rows[] = '{
    // coincident, arbitrary velocities pass through
    '{'{32'h1000_0000, 32'h1000_0000, 24'd5, 32'h0001_2345, 32'hFFFE_0000,
        32'h1000_0000, 32'h1000_0000, 24'd9, 32'h0000_0007, 32'h8765_4321},
      1'b1, '{32'h0001_2345, 32'hFFFE_0000, 32'h0000_0007, 32'h8765_4321, 1'b1}},
    // coincident at the top corner, velocity extremes
    '{'{VMAX, VMAX, MMAX, VMIN, VMAX, VMAX, VMAX, MMAX, VMAX, VMIN},
      1'b1, '{VMIN, VMAX, VMAX, VMIN, 1'b1}},
    // one LSB apart in x, heaviest masses: kick capped, both x saturate
    '{'{32'd0, 32'd0, MMAX, 32'd0, 32'd0, 32'd1, 32'd0, MMAX, 32'd0, 32'd0},
      1'b1, '{VMAX, 32'd0, VMIN, 32'd0, 1'b0}},
    // one LSB apart in y, velocities at the far extremes, still saturate
    '{'{32'd0, 32'd0, MMAX, 32'd5, VMIN, 32'd0, 32'd1, MMAX, 32'd7, VMAX},
      1'b1, '{32'd5, VMAX, 32'd7, VMIN, 1'b0}},
    // both massless: nobody pulls
    '{'{32'h0001_0000, 32'd0, 24'd0, 32'h1234_5678, 32'hDEAD_BEEF,
        32'd0, 32'h0002_0000, 24'd0, 32'h0BAD_F00D, 32'h0000_0001},
      1'b1, '{32'h1234_5678, 32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h0000_0001, 1'b0}},
    '{'{VMIN, VMIN, MMAX, VMAX, VMIN, VMAX, VMAX, MMAX, VMIN, VMAX}, 1'b0, '0},
    '{'{VMAX, VMAX, MMAX, 32'd0, 32'd0, VMIN, VMIN, MMAX, 32'd0, 32'd0}, 1'b0, '0},
    '{'{VMIN, 32'd0, 24'd1, VMIN, VMAX, VMAX, 32'd0, 24'd1, VMAX, VMIN}, 1'b0, '0},
    // first body massless, second heavy
    '{'{32'd0, 32'd0, 24'd0, 32'd0, 32'd0, 32'h0003_0000, 32'h0004_0000, 24'd5000,
        32'd0, 32'd0}, 1'b0, '0},
    // second body massless
    '{'{32'd0, 32'd0, 24'd5000, 32'd0, 32'd0, 32'hFFFD_0000, 32'hFFFC_0000, 24'd0,
        32'd0, 32'd0}, 1'b0, '0},
    '{'{32'h0005_0000, 32'h0005_0000, 24'd1000, 32'h0001_0000, 32'hFFFF_0000,
        32'h0002_0000, 32'h0001_0000, 24'd1000, 32'hFFFF_0000, 32'h0001_0000}, 1'b0, '0},
    '{'{32'h0000_0100, 32'hFFFF_FF00, 24'd77, 32'h4000_0000, 32'hC000_0000,
        32'hFFFF_FF00, 32'h0000_0100, MMAX, 32'hC000_0000, 32'h4000_0000}, 1'b0, '0},
    '{'{32'd3, 32'd4, 24'd123456, 32'd0, 32'd0, 32'd0, 32'd0, 24'd654321,
        32'd0, 32'd0}, 1'b0, '0}
  };

  // ---------------------------------------------------------------- random pairs
  function automatic logic [23:0] pick_mass();
    case ($urandom_range(7))
      0:       return 24'd0;
      1:       return MMAX;
      2, 3:    return 24'($urandom_range(1000));
      default: return 24'($urandom);
    endcase
  endfunction

  // Half the pairs are nearby bodies so kicks land in range; some coincident, some far.
  function automatic body_pair_t rand_pair();
    body_pair_t p;
    int         span;
    p.first_pos_x = $urandom;
    p.first_pos_y = $urandom;
    p.first_vel_x = $urandom;
    p.first_vel_y = $urandom;
    p.second_vel_x = $urandom;
    p.second_vel_y = $urandom;
    p.first_mass  = pick_mass();
    p.second_mass = pick_mass();
    case ($urandom_range(9))
      0: begin
        p.second_pos_x = p.first_pos_x;
        p.second_pos_y = p.first_pos_y;
      end
      1, 2, 3, 4, 5: begin
        span = $urandom_range(30, 4);
        p.second_pos_x = p.first_pos_x + ($signed($urandom) >>> (32 - span));
        p.second_pos_y = p.first_pos_y + ($signed($urandom) >>> (32 - span));
      end
      default: begin
        p.second_pos_x = $urandom;
        p.second_pos_y = $urandom;
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------- driving
  initial begin
    in_ch.valid = 1'b0;
    {in_ch.first_pos_x, in_ch.first_pos_y, in_ch.first_mass, in_ch.first_vel_x,
     in_ch.first_vel_y, in_ch.second_pos_x, in_ch.second_pos_y, in_ch.second_mass,
     in_ch.second_vel_x, in_ch.second_vel_y} = '0;
    out_ch.ready = 1'b0;
  end

  // Offer one pair; hold it until the block takes it, then queue the expectation.
  task automatic send_pair(body_pair_t p, logic typed, res_t given);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.first_pos_x  = p.first_pos_x;
    in_ch.first_pos_y  = p.first_pos_y;
    in_ch.first_mass   = p.first_mass;
    in_ch.first_vel_x  = p.first_vel_x;
    in_ch.first_vel_y  = p.first_vel_y;
    in_ch.second_pos_x = p.second_pos_x;
    in_ch.second_pos_y = p.second_pos_y;
    in_ch.second_mass  = p.second_mass;
    in_ch.second_vel_x = p.second_vel_x;
    in_ch.second_vel_y = p.second_vel_y;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    kicked_q.push_back(typed ? given : predict_kick(p));
    pairs_in++;
  endtask

  // Drop valid and wait until every expected beat has come out.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (kicked_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic write_gravity(logic [G_W-1:0] g);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_wdata = g;
    grav_g    = g;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // Three idle patterns by item count: sender-light, receiver-light, none.
  task automatic pick_idle();
    if (pairs_in < 700) begin
      tx_idle_pct = 25; rx_idle_pct = 75;
    end else if (pairs_in < 1400) begin
      tx_idle_pct = 75; rx_idle_pct = 25;
    end else begin
      tx_idle_pct = 0;  rx_idle_pct = 0;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checking
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("tb: %0t mismatch %s got %h want %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      vels_out++;
      if (kicked_q.size() == 0) begin
        errors++;
        $display("tb: %0t velocity beat with nothing expected", $realtime);
      end else begin
        want = kicked_q.pop_front();
        if (out_ch.coincident) coin_seen++;
        if (out_ch.new_first_vel_x !== want.nfvx)
          report("new_first_vel_x", out_ch.new_first_vel_x, want.nfvx);
        if (out_ch.new_first_vel_y !== want.nfvy)
          report("new_first_vel_y", out_ch.new_first_vel_y, want.nfvy);
        if (out_ch.new_second_vel_x !== want.nsvx)
          report("new_second_vel_x", out_ch.new_second_vel_x, want.nsvx);
        if (out_ch.new_second_vel_y !== want.nsvy)
          report("new_second_vel_y", out_ch.new_second_vel_y, want.nsvy);
        if (out_ch.coincident !== want.coin)
          report("coincident", 32'(out_ch.coincident), 32'(want.coin));
      end
    end
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  always @(posedge clk) begin
    int quiet;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: timeout after %0d quiet cycles", quiet);
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [G_W-1:0] g_phase[NUM_PHASES];
    g_phase[0] = G_RESET;
    g_phase[1] = 32'h0000_0000;
    g_phase[2] = 32'hFFFF_FFFF;
    g_phase[3] = $urandom;
    g_phase[4] = 32'h0000_0001;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows run at the reset value of G.
    foreach (dir_rows[i]) begin
      pick_idle();
      send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].vels);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // G changes only with the pipe empty.
      if (ph > 0) begin
        drain();
        write_gravity(g_phase[ph]);
      end
      // Hold the receiver off long enough to back the pipe up into the input.
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_idle();
        send_pair(rand_pair(), 1'b0, '0);
      end
    end

    drain();
    $display("tb: %0d pairs in, %0d velocity beats out, %0d coincident", pairs_in,
             vels_out, coin_seen);
    $display("tb: covered %0d G settings incl. 0 and all-ones, idle mixes, long hold-off",
             NUM_PHASES);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- pairwise_gravity_velocity_update.f -----
+incdir+rtl
rtl/pgvu_pkg.sv
rtl/pgvu_channels.sv
rtl/pgvu_isqrt.sv
rtl/pgvu_kdiv.sv
rtl/pairwise_gravity_velocity_update.sv
tb/testbench.sv
